FILE: src/rsa_modular_exponentiation_defines.svh
// assertion macros for the rsa modular exponentiation rtl
`ifndef RSA_MODULAR_EXPONENTIATION_DEFINES_SVH
`define RSA_MODULAR_EXPONENTIATION_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define RME_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
`define RME_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`else
`define RME_ASSERT(lbl, clk, rst_n, prop)
`define RME_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

FILE: src/rme_pkg.sv
// shared types and constants of the rsa modular exponentiation block
package rme_pkg;
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LAUNCH,
		ST_WAIT,
		ST_FINISH
	} state_t;

	localparam logic [1:0] REG_MODULUS          = 2'd0;
	localparam logic [1:0] REG_PUBLIC_EXPONENT  = 2'd1;
	localparam logic [1:0] REG_PRIVATE_EXPONENT = 2'd2;

	localparam int unsigned FIELD_BITS = 32;
endpackage

FILE: src/rme_cell.sv
// one interleaved modular multiply step, two lanes sharing a multiplier bit
module rme_cell #(
	parameter int WORD_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid_in,
	input  logic [WORD_BITS-1:0] p1_in,
	input  logic [WORD_BITS-1:0] p2_in,
	input  logic [WORD_BITS-1:0] a1_in,
	input  logic [WORD_BITS-1:0] a2_in,
	input  logic [WORD_BITS-1:0] m_in,
	input  logic [WORD_BITS-1:0] b_in,
	output logic                 valid_out,
	output logic [WORD_BITS-1:0] p1_out,
	output logic [WORD_BITS-1:0] p2_out,
	output logic [WORD_BITS-1:0] a1_out,
	output logic [WORD_BITS-1:0] a2_out,
	output logic [WORD_BITS-1:0] m_out,
	output logic [WORD_BITS-1:0] b_out
);
	logic [WORD_BITS-1:0] p1_d, p2_d;

	// p' = (2p + bit*a) mod m, with p, a below m
	function automatic logic [WORD_BITS-1:0] step(input logic [WORD_BITS-1:0] p,
			input logic [WORD_BITS-1:0] a, input logic [WORD_BITS-1:0] m,
			input logic bit_i);
		logic [WORD_BITS:0] t;
		logic [WORD_BITS:0] u;
		t = {p, 1'b0};
		if (t >= {1'b0, m}) t = t - {1'b0, m};
		u = t + (bit_i ? {1'b0, a} : '0);
		if (u >= {1'b0, m}) u = u - {1'b0, m};
		return u[WORD_BITS-1:0];
	endfunction

	always_comb begin
		p1_d = step(p1_in, a1_in, m_in, b_in[WORD_BITS-1]);
		p2_d = step(p2_in, a2_in, m_in, b_in[WORD_BITS-1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		p1_out <= p1_d;
		p2_out <= p2_d;
		a1_out <= a1_in;
		a2_out <= a2_in;
		m_out  <= m_in;
		b_out  <= {b_in[WORD_BITS-2:0], 1'b0};
	end
endmodule

FILE: src/rme_chain.sv
// row of multiply cells, one multiplier bit per cell, msb first
module rme_chain #(
	parameter int WORD_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid_in,
	input  logic [WORD_BITS-1:0] a1_in,
	input  logic [WORD_BITS-1:0] a2_in,
	input  logic [WORD_BITS-1:0] m_in,
	input  logic [WORD_BITS-1:0] b_in,
	output logic                 valid_out,
	output logic [WORD_BITS-1:0] p1_out,
	output logic [WORD_BITS-1:0] p2_out
);
	logic                 v  [WORD_BITS+1];
	logic [WORD_BITS-1:0] p1 [WORD_BITS+1];
	logic [WORD_BITS-1:0] p2 [WORD_BITS+1];
	logic [WORD_BITS-1:0] a1 [WORD_BITS+1];
	logic [WORD_BITS-1:0] a2 [WORD_BITS+1];
	logic [WORD_BITS-1:0] m  [WORD_BITS+1];
	logic [WORD_BITS-1:0] b  [WORD_BITS+1];

	assign v[0]  = valid_in;
	assign p1[0] = '0;
	assign p2[0] = '0;
	assign a1[0] = a1_in;
	assign a2[0] = a2_in;
	assign m[0]  = m_in;
	assign b[0]  = b_in;

	for (genvar i = 0; i < WORD_BITS; i++) begin : g_cell
		rme_cell #(.WORD_BITS(WORD_BITS)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.valid_in(v[i]), .p1_in(p1[i]), .p2_in(p2[i]),
			.a1_in(a1[i]), .a2_in(a2[i]), .m_in(m[i]), .b_in(b[i]),
			.valid_out(v[i+1]), .p1_out(p1[i+1]), .p2_out(p2[i+1]),
			.a1_out(a1[i+1]), .a2_out(a2[i+1]), .m_out(m[i+1]), .b_out(b[i+1])
		);
	end

	assign valid_out = v[WORD_BITS];
	assign p1_out    = p1[WORD_BITS];
	assign p2_out    = p2[WORD_BITS];
endmodule

FILE: src/rsa_modular_exponentiation.sv
// top level: modular exponentiation by square-and-multiply over a cell chain
//
// channel  direction  handshake              payload
// cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
// in       in         in_valid / in_stall    mode, message_value
// out      out        out_valid / out_stall  result_value
//
// one item takes (WORD_BITS+1) passes through the WORD_BITS-cell multiply chain,
// each pass a launch state and then a wait state until the chain returns, with
// an accept in idle before the first pass and a finish state after the last
// the first pass reduces the base, each later pass forms acc*sq and sq*sq at once
// reset loads modulus 2 and both exponents 1; cfg_ready is always high
// a finished result waits in the output register; the next item is taken meanwhile,
// and its own finish holds the input stalled until that register frees
`include "rsa_modular_exponentiation_defines.svh"
module rsa_modular_exponentiation #(
	parameter int WORD_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [1:0]                        cfg_index,
	input  logic [rme_pkg::FIELD_BITS-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              mode,
	input  logic [rme_pkg::FIELD_BITS-1:0]    message_value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [rme_pkg::FIELD_BITS-1:0]    result_value
);
	localparam int PW = $clog2(WORD_BITS + 1);
	localparam int KW = $clog2(WORD_BITS);

	// configuration registers
	logic [WORD_BITS-1:0] modulus_q, pub_exp_q, priv_exp_q;

	// per item working state
	rme_pkg::state_t      state_q, state_d;
	logic [PW-1:0]        pass_q;
	logic [WORD_BITS-1:0] acc_q, sq_q, exp_q, m_q, base_q;
	logic                 out_valid_q;
	logic [rme_pkg::FIELD_BITS-1:0] result_q;

	// chain interface
	logic                 ch_valid_in, ch_valid_out;
	logic [WORD_BITS-1:0] ch_a1, ch_a2, ch_b, ch_p1, ch_p2;
	logic [PW-1:0]        kfull;
	logic [KW-1:0]        kidx;
	logic                 out_free;
	logic [WORD_BITS-1:0] final_val;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q  <= WORD_BITS'(2);
			pub_exp_q  <= WORD_BITS'(1);
			priv_exp_q <= WORD_BITS'(1);
		end else if (cfg_valid) begin
			case (cfg_index)
				rme_pkg::REG_MODULUS:          modulus_q  <= cfg_data[WORD_BITS-1:0];
				rme_pkg::REG_PUBLIC_EXPONENT:  pub_exp_q  <= cfg_data[WORD_BITS-1:0];
				rme_pkg::REG_PRIVATE_EXPONENT: priv_exp_q <= cfg_data[WORD_BITS-1:0];
				default: ;
			endcase
		end
	end

	// pass 0 reduces the base: 1 * base mod m, lane two
	assign ch_valid_in = (state_q == rme_pkg::ST_LAUNCH);
	assign ch_a1 = (pass_q == '0) ? WORD_BITS'(1) : acc_q;
	assign ch_a2 = (pass_q == '0) ? WORD_BITS'(1) : sq_q;
	assign ch_b  = (pass_q == '0) ? base_q : sq_q;

	rme_chain #(.WORD_BITS(WORD_BITS)) u_chain (
		.clk(clk), .arst_n(arst_n),
		.valid_in(ch_valid_in), .a1_in(ch_a1), .a2_in(ch_a2),
		.m_in(m_q), .b_in(ch_b),
		.valid_out(ch_valid_out), .p1_out(ch_p1), .p2_out(ch_p2)
	);

	assign kfull    = pass_q - PW'(1);
	assign kidx     = kfull[KW-1:0];
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != rme_pkg::ST_IDLE);

	// zero exponent gives 1, degenerate modulus gives 0
	always_comb begin
		if (exp_q == '0) final_val = WORD_BITS'(1);
		else if (m_q < WORD_BITS'(2)) final_val = '0;
		else final_val = acc_q;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			rme_pkg::ST_IDLE:   if (in_valid) state_d = rme_pkg::ST_LAUNCH;
			rme_pkg::ST_LAUNCH: state_d = rme_pkg::ST_WAIT;
			rme_pkg::ST_WAIT: begin
				if (ch_valid_out) begin
					state_d = (pass_q == PW'(WORD_BITS)) ? rme_pkg::ST_FINISH
						: rme_pkg::ST_LAUNCH;
				end
			end
			rme_pkg::ST_FINISH: if (out_free) state_d = rme_pkg::ST_IDLE;
			default:            state_d = rme_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rme_pkg::ST_IDLE;
			pass_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// the count stops at the last pass
			if (state_q == rme_pkg::ST_IDLE && in_valid) pass_q <= '0;
			else if (state_q == rme_pkg::ST_WAIT && ch_valid_out
					&& pass_q != PW'(WORD_BITS)) pass_q <= pass_q + PW'(1);
			if (state_q == rme_pkg::ST_FINISH && out_free) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rme_pkg::ST_IDLE && in_valid) begin
			base_q <= message_value[WORD_BITS-1:0];
			exp_q  <= mode ? priv_exp_q : pub_exp_q;
			m_q    <= modulus_q;
			acc_q  <= WORD_BITS'(1);
		end
		if (state_q == rme_pkg::ST_WAIT && ch_valid_out) begin
			sq_q <= ch_p2;
			if (pass_q != '0 && exp_q[kidx]) acc_q <= ch_p1;
		end
		if (state_q == rme_pkg::ST_FINISH && out_free) begin
			result_q <= rme_pkg::FIELD_BITS'(final_val);
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = result_q;

	`RME_ASSERT(a_chain_only_in_wait, clk, arst_n, !ch_valid_out || state_q == rme_pkg::ST_WAIT)
	`RME_ASSERT(a_accept_only_idle, clk, arst_n, !(in_valid && !in_stall) || state_q == rme_pkg::ST_IDLE)
	`RME_ASSERT(a_pass_bound, clk, arst_n, pass_q <= PW'(WORD_BITS))
	`RME_ASSERT_NEXT(a_result_loaded, clk, arst_n, state_q == rme_pkg::ST_FINISH && out_free, out_valid)
endmodule

FILE: tb/sv/tb_rsa_modular_exponentiation.sv
// testbench for the rsa modular exponentiation block: directed table, then random items
`timescale 1ns / 1ps
module tb_rsa_modular_exponentiation;
	localparam int unsigned LIMIT_CYCLES = 3_000_000;
	localparam int unsigned HOLD_CYCLES  = 4000;
	localparam int unsigned TAIL_CYCLES  = 1200;
	localparam int unsigned RAND_ITEMS   = 85;

	typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

	// one line of the directed table: a register write or an item
	typedef struct {
		row_kind_t                       kind;
		logic [1:0]                      index;
		logic [rme_pkg::FIELD_BITS-1:0]  data;
		logic                            op_mode;
		logic [rme_pkg::FIELD_BITS-1:0]  value;
		bit                              known;
		logic [rme_pkg::FIELD_BITS-1:0]  power;
	} row_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [1:0]                     cfg_index;
	logic [rme_pkg::FIELD_BITS-1:0] cfg_data;
	logic                           in_valid;
	logic                           in_stall;
	logic                           mode;
	logic [rme_pkg::FIELD_BITS-1:0] message_value;
	logic                           out_valid;
	logic                           out_stall;
	logic [rme_pkg::FIELD_BITS-1:0] result_value;

	// shadow copy of the key registers
	logic [rme_pkg::FIELD_BITS-1:0] key_modulus;
	logic [rme_pkg::FIELD_BITS-1:0] key_public;
	logic [rme_pkg::FIELD_BITS-1:0] key_private;

	logic [rme_pkg::FIELD_BITS-1:0] pending_powers[$];
	row_t                           dir_rows[$];
	int unsigned                    errors;
	int unsigned                    cycles;
	int unsigned                    send_idle_pct;
	int unsigned                    recv_idle_pct;
	int unsigned                    accepted;
	logic                           long_hold;

	rsa_modular_exponentiation u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.message_value (message_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.result_value  (result_value)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// right-to-left square-and-multiply with 64-bit products
	function automatic logic [rme_pkg::FIELD_BITS-1:0] mod_power(
			logic [rme_pkg::FIELD_BITS-1:0] base,
			logic [rme_pkg::FIELD_BITS-1:0] expo, logic [rme_pkg::FIELD_BITS-1:0] m);
		logic [63:0] acc;
		logic [63:0] sq;
		logic [63:0] m64;
		if (expo == '0)
			return 1;
		// out-of-range modulus gives zero, no division
		if (m < 2)
			return '0;
		m64 = {32'd0, m};
		acc = 64'd1;
		sq  = {32'd0, base} % m64;
		for (int k = 0; k < rme_pkg::FIELD_BITS; k++) begin
			if (expo[k])
				acc = (acc * sq) % m64;
			sq = (sq * sq) % m64;
		end
		return acc[rme_pkg::FIELD_BITS-1:0];
	endfunction

	// append one row to the directed table
	task automatic add_row(input row_t r);
		dir_rows.insert(dir_rows.size(), r);
	endtask

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("tb_rsa_modular_exponentiation: done, errors");
			$finish;
		end
	end

	// result side: check each accepted result, then pick the next stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b1;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_powers.size() == 0) begin
					$display("%0t: unexpected result_value, expected none, actual %h",
						$time, result_value);
					errors++;
				end else begin
					if (result_value !== pending_powers[0]) begin
						$display("%0t: result_value mismatch, expected %h, actual %h",
							$time, pending_powers[0], result_value);
						errors++;
					end
					void'(pending_powers.pop_front());
				end
			end
			out_stall <= long_hold || ($urandom_range(99) < recv_idle_pct);
		end
	end

	// long receiver hold-off while the sender keeps offering items
	initial begin
		long_hold = 1'b0;
		wait (accepted >= 20);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		long_hold <= 1'b0;
	end

	// offer one item and hold it until taken; expectation formed at the accepting edge
	task automatic send_item(input logic op_mode, input logic [rme_pkg::FIELD_BITS-1:0] value,
			input bit known, input logic [rme_pkg::FIELD_BITS-1:0] power);
		in_valid      <= 1'b1;
		mode          <= op_mode;
		message_value <= value;
		do @(posedge clk); while (in_stall);
		if (known)
			pending_powers.insert(pending_powers.size(), power);
		else
			pending_powers.insert(pending_powers.size(),
				mod_power(value, op_mode ? key_private : key_public, key_modulus));
		accepted++;
		// random gap after the item
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
	endtask

	// stop offering and wait until every expected result is back
	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_powers.size() != 0) @(posedge clk);
	endtask

	// register write, only with nothing in flight
	task automatic write_key(input logic [1:0] index,
			input logic [rme_pkg::FIELD_BITS-1:0] data);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (index)
			rme_pkg::REG_MODULUS:         key_modulus = data;
			rme_pkg::REG_PUBLIC_EXPONENT: key_public  = data;
			default:                      key_private = data;
		endcase
		@(posedge clk);
	endtask

	function automatic logic [rme_pkg::FIELD_BITS-1:0] rand_exponent();
		case ($urandom_range(7))
			0:       return '0;
			1:       return '1;
			2:       return $urandom_range(1, 40);
			default: return $urandom;
		endcase
	endfunction

	// mostly full-width values, some small, some at the extremes
	function automatic logic [rme_pkg::FIELD_BITS-1:0] rand_message();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			2:       return key_modulus;
			3:       return $urandom_range(0, 255);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = rme_pkg::REG_MODULUS;
		cfg_data      = '0;
		in_valid      = 1'b0;
		mode          = 1'b0;
		message_value = '0;
		errors        = 0;
		cycles        = 0;
		accepted      = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		key_modulus   = 2;
		key_public    = 1;
		key_private   = 1;

		// reset values: modulus 2, both exponents 1
		add_row('{ROW_ITEM, rme_pkg::REG_MODULUS, '0, 1'b0, 32'h0000_0000, 1, 32'h0});
		add_row('{ROW_ITEM, rme_pkg::REG_MODULUS, '0, 1'b0, 32'hFFFF_FFFF, 1, 32'h1});
		add_row('{ROW_ITEM, rme_pkg::REG_MODULUS, '0, 1'b1, 32'h0000_0003, 1, 32'h1});
		// zero exponent gives one, even for a zero base
		add_row('{ROW_CFG, rme_pkg::REG_PUBLIC_EXPONENT, 32'h0, 1'b0, '0, 0, '0});
		add_row('{ROW_ITEM, rme_pkg::REG_MODULUS, '0, 1'b0, 32'h0000_3039, 1, 32'h1});
		add_row('{ROW_CFG, rme_pkg::REG_PRIVATE_EXPONENT, 32'h0, 1'b0, '0, 0, '0});
		add_row('{ROW_ITEM, rme_pkg::REG_MODULUS, '0, 1'b1, 32'h0000_0000, 1, 32'h1});
		// full-width modulus and private exponent, public exponent 65537; base equal to modulus reduces to zero
		add_row('{ROW_CFG, rme_pkg::REG_MODULUS, 32'hFFFF_FFFF, 1'b0, '0, 0, '0});
		add_row('{ROW_CFG, rme_pkg::REG_PUBLIC_EXPONENT, 32'h0001_0001, 1'b0, '0, 0, '0});
		add_row('{ROW_CFG, rme_pkg::REG_PRIVATE_EXPONENT, 32'hFFFF_FFFF, 1'b0, '0, 0, '0});
		add_row('{ROW_ITEM, rme_pkg::REG_MODULUS, '0, 1'b0, 32'hFFFF_FFFF, 1, 32'h0});
		add_row('{ROW_ITEM, rme_pkg::REG_MODULUS, '0, 1'b1, 32'hFFFF_FFFE, 0, '0});
		add_row('{ROW_ITEM, rme_pkg::REG_MODULUS, '0, 1'b0, 32'h0000_0002, 0, '0});
		// modulus zero and one are out of range: zero unless the exponent is zero
		add_row('{ROW_CFG, rme_pkg::REG_MODULUS, 32'h0, 1'b0, '0, 0, '0});
		add_row('{ROW_ITEM, rme_pkg::REG_MODULUS, '0, 1'b0, 32'h0000_0005, 1, 32'h0});
		add_row('{ROW_CFG, rme_pkg::REG_MODULUS, 32'h1, 1'b0, '0, 0, '0});
		add_row('{ROW_ITEM, rme_pkg::REG_MODULUS, '0, 1'b1, 32'h0000_0007, 1, 32'h0});
		add_row('{ROW_CFG, rme_pkg::REG_PUBLIC_EXPONENT, 32'h0, 1'b0, '0, 0, '0});
		add_row('{ROW_ITEM, rme_pkg::REG_MODULUS, '0, 1'b0, 32'h0000_0009, 1, 32'h1});
		// textbook key n = 61 * 53, e = 17, d = 2753
		add_row('{ROW_CFG, rme_pkg::REG_MODULUS, 32'd3233, 1'b0, '0, 0, '0});
		add_row('{ROW_CFG, rme_pkg::REG_PUBLIC_EXPONENT, 32'd17, 1'b0, '0, 0, '0});
		add_row('{ROW_CFG, rme_pkg::REG_PRIVATE_EXPONENT, 32'd2753, 1'b0, '0, 0, '0});
		add_row('{ROW_ITEM, rme_pkg::REG_MODULUS, '0, 1'b0, 32'd65, 1, 32'd2790});
		add_row('{ROW_ITEM, rme_pkg::REG_MODULUS, '0, 1'b1, 32'd2790, 1, 32'd65});
		add_row('{ROW_ITEM, rme_pkg::REG_MODULUS, '0, 1'b0, 32'd5000, 0, '0});

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table at full rate
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG)
				write_key(dir_rows[i].index, dir_rows[i].data);
			else
				send_item(dir_rows[i].op_mode, dir_rows[i].value, dir_rows[i].known,
					dir_rows[i].power);
		end

		// random phases: sender idles 24 / receiver 74, then swapped, then no idling
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 74 : 0;
			recv_idle_pct = (phase == 0) ? 74 : (phase == 1) ? 24 : 0;
			for (int n = 0; n < RAND_ITEMS; n++) begin
				// new key every so often, on an idle block
				if (n % 20 == 0) begin
					write_key(rme_pkg::REG_MODULUS, ($urandom_range(3) == 0) ?
						$urandom_range(0, 400) : $urandom);
					write_key(rme_pkg::REG_PUBLIC_EXPONENT, rand_exponent());
					write_key(rme_pkg::REG_PRIVATE_EXPONENT, rand_exponent());
				end
				// one mid-phase pause until every result is back
				if (n == 45)
					drain();
				send_item($urandom_range(1), rand_message(), 0, '0);
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb_rsa_modular_exponentiation: done, clean");
		else
			$display("tb_rsa_modular_exponentiation: done, errors");
		$finish;
	end
endmodule

FILE: rsa_modular_exponentiation.f
+incdir+src
src/rme_pkg.sv
src/rme_cell.sv
src/rme_chain.sv
src/rsa_modular_exponentiation.sv
tb/sv/tb_rsa_modular_exponentiation.sv
